// ===== hw/rtl/pli_pkg.sv =====
// ----------------------------------------------------------------------------
// pli_pkg
// Shared codes and types for the pooled list insert/remove core.
// ----------------------------------------------------------------------------
package pli_pkg;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } pli_status_t;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef struct packed {
    logic val_we;
    logic link_we;
  } pli_wr_ctl_t;

endpackage

// ===== hw/rtl/pli_node_store.sv =====
// ----------------------------------------------------------------------------
// pli_node_store
// Node value and link memories with registered read. Untouched nodes are
// tracked by a fill count and read back their reset link (next node or null).
// ----------------------------------------------------------------------------
module pli_node_store
  import pli_pkg::*;
#(
  parameter int POOL_NODES = 64,
  parameter int VALUE_BITS = 8,
  localparam int IW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1,
  localparam int LW = $clog2(POOL_NODES + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [IW-1:0]         rd_addr,
  output logic [VALUE_BITS-1:0] rd_value,
  output logic [LW-1:0]         rd_link,
  input  pli_wr_ctl_t           wr_ctl,
  input  logic [IW-1:0]         wr_val_addr,
  input  logic [VALUE_BITS-1:0] wr_val_data,
  input  logic [IW-1:0]         wr_link_addr,
  input  logic [LW-1:0]         wr_link_data
);

  logic [VALUE_BITS-1:0] val_mem [POOL_NODES];
  logic [LW-1:0]         link_mem [POOL_NODES];
  logic [LW-1:0]         link_raw;
  logic [IW-1:0]         addr_q;
  logic [LW-1:0]         fill;

  always_ff @(posedge clk) begin
    if (wr_ctl.val_we) begin
      val_mem[wr_val_addr] <= wr_val_data;
    end
    if (wr_ctl.link_we) begin
      link_mem[wr_link_addr] <= wr_link_data;
    end
    rd_value <= val_mem[rd_addr];
    link_raw <= link_mem[rd_addr];
    addr_q   <= rd_addr;
  end

  // node taken off the fresh part of the free list
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (wr_ctl.link_we && (LW'(wr_link_addr) == fill)) begin
      fill <= fill + LW'(1);
    end
  end

  always_comb begin
    if (LW'(addr_q) < fill) begin
      rd_link = link_raw;
    end else if (addr_q == IW'(POOL_NODES - 1)) begin
      rd_link = LW'(POOL_NODES);
    end else begin
      rd_link = LW'(addr_q) + LW'(1);
    end
  end

endmodule

// ===== hw/rtl/pooled_list_insert_remove_core.sv =====
// ----------------------------------------------------------------------------
// pooled_list_insert_remove_core
// Bag of values in a fixed node pool: occupied list plus free list.
// ----------------------------------------------------------------------------
// Usage:
//   Input request (in_valid/in_stall): op = insert (0) or remove (1), value.
//   Output request (out_valid/out_stall): status (done, full, not found) and
//   the occupied count after the request. One result per input request.
//   The core takes one request at a time; in_stall is high while it works.
//   Path from accept to result register:
//     insert: S_INS (straight to the result when the pool is full),
//     remove: S_WALK over k nodes (1 .. used count, at most POOL_NODES),
//     then S_FREE; straight to the result when the list is empty.
//   The walk visits one node per cycle through the node memory read port.
//   The result sits in an output register; a new request is taken only in
//   the cycle the result leaves or once it is gone, so in_stall stays high
//   while out_stall holds a result.
//   Reset (rst, synchronous) empties the occupied list and restores the free
//   list at once through a fill count; no clearing pass is needed.
// ----------------------------------------------------------------------------
module pooled_list_insert_remove_core
  import pli_pkg::*;
#(
  parameter int POOL_NODES = 64,
  parameter int VALUE_BITS = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       op,
  input  logic [7:0] value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] status,
  output logic [6:0] occupied_count
);

  localparam int IW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
  localparam int LW = $clog2(POOL_NODES + 1);
  localparam logic [LW-1:0] NULL_LINK = LW'(POOL_NODES);

  typedef enum logic [1:0] {S_IDLE, S_INS, S_WALK, S_FREE} state_t;

  state_t                state;
  logic [VALUE_BITS-1:0] val;
  logic [LW-1:0]         occ_head;
  logic [LW-1:0]         free_head;
  logic [LW-1:0]         used;
  logic [LW-1:0]         cur;
  logic [LW-1:0]         prev;
  logic [LW-1:0]         steps;

  logic                  out_free;
  logic                  accept;
  logic [VALUE_BITS+7:0] val_ext;
  logic [VALUE_BITS-1:0] val_in;
  logic [LW+6:0]         cnt_inc;
  logic [LW+6:0]         cnt_dec;
  logic [LW+6:0]         cnt_same;

  logic [IW-1:0]         rd_addr;
  logic [VALUE_BITS-1:0] rd_value;
  logic [LW-1:0]         rd_link;
  pli_wr_ctl_t           wr_ctl;
  logic [IW-1:0]         wr_link_addr;
  logic [LW-1:0]         wr_link_data;
  logic                  cur_ok;
  logic                  hit;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;

  assign val_ext  = {{VALUE_BITS{1'b0}}, value};
  assign val_in   = val_ext[VALUE_BITS-1:0];
  assign cnt_inc  = {7'd0, used + LW'(1)};
  assign cnt_dec  = {7'd0, used - LW'(1)};
  assign cnt_same = {7'd0, used};

  assign cur_ok = cur < NULL_LINK;
  assign hit    = rd_value == val;

  always_comb begin
    case (state)
      S_IDLE:  rd_addr = (op == OP_REMOVE) ? occ_head[IW-1:0] : free_head[IW-1:0];
      S_WALK:  rd_addr = rd_link[IW-1:0];
      default: rd_addr = free_head[IW-1:0];
    endcase
  end

  always_comb begin
    wr_ctl       = '0;
    wr_link_addr = free_head[IW-1:0];
    wr_link_data = occ_head;
    case (state)
      S_INS: begin
        if (out_free) begin
          wr_ctl.val_we  = 1'b1;
          wr_ctl.link_we = 1'b1;
        end
      end
      S_WALK: begin
        wr_link_addr = prev[IW-1:0];
        wr_link_data = rd_link;
        wr_ctl.link_we = cur_ok && hit && (prev != NULL_LINK);
      end
      S_FREE: begin
        wr_link_addr = cur[IW-1:0];
        wr_link_data = free_head;
        wr_ctl.link_we = out_free && (cur != NULL_LINK);
      end
      default: begin
      end
    endcase
  end

  pli_node_store #(
    .POOL_NODES (POOL_NODES),
    .VALUE_BITS (VALUE_BITS)
  ) u_store (
    .clk          (clk),
    .rst          (rst),
    .rd_addr      (rd_addr),
    .rd_value     (rd_value),
    .rd_link      (rd_link),
    .wr_ctl       (wr_ctl),
    .wr_val_addr  (free_head[IW-1:0]),
    .wr_val_data  (val),
    .wr_link_addr (wr_link_addr),
    .wr_link_data (wr_link_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occ_head  <= NULL_LINK;
      free_head <= '0;
      used      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            val <= val_in;
            if (op == OP_INSERT) begin
              if (free_head == NULL_LINK) begin
                out_valid      <= 1'b1;
                status         <= ST_FULL;
                occupied_count <= cnt_same[6:0];
              end else begin
                state <= S_INS;
              end
            end else if (used == '0) begin
              out_valid      <= 1'b1;
              status         <= ST_NOT_FOUND;
              occupied_count <= cnt_same[6:0];
            end else begin
              cur   <= occ_head;
              prev  <= NULL_LINK;
              steps <= '0;
              state <= S_WALK;
            end
          end
        end
        S_INS: begin
          if (out_free) begin
            occ_head       <= free_head;
            free_head      <= rd_link;
            used           <= used + LW'(1);
            out_valid      <= 1'b1;
            status         <= ST_DONE;
            occupied_count <= cnt_inc[6:0];
            state          <= S_IDLE;
          end
        end
        S_WALK: begin
          if (!cur_ok) begin
            state <= S_FREE;
            cur   <= NULL_LINK;
          end else if (hit) begin
            if (prev == NULL_LINK) begin
              occ_head <= rd_link;
            end
            state <= S_FREE;
          end else if (steps + LW'(1) == used) begin
            cur   <= NULL_LINK;
            state <= S_FREE;
          end else begin
            prev  <= cur;
            cur   <= rd_link;
            steps <= steps + LW'(1);
          end
        end
        S_FREE: begin
          // cur is null when the walk missed
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
            if (cur == NULL_LINK) begin
              status         <= ST_NOT_FOUND;
              occupied_count <= cnt_same[6:0];
            end else begin
              free_head      <= cur;
              used           <= used - LW'(1);
              status         <= ST_DONE;
              occupied_count <= cnt_dec[6:0];
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== dv/pooled_list_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pooled_list_checker
// Tracks the occupied list and the free list of the node pool from accepted
// requests, predicts status and occupied count for each one, and compares
// every accepted result against the oldest prediction still due.
// ----------------------------------------------------------------------------
module pooled_list_checker
  import pli_pkg::*;
#(
  parameter int POOL_NODES = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic       op,
  input  logic [7:0] value,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [1:0] status,
  input  logic [6:0] occupied_count,
  output int         fail_count,
  output int         pending
);

  localparam logic [6:0] NIL = 7'(POOL_NODES);

  typedef struct {
    pli_status_t status;
    logic [6:0]  count;
  } list_result_t;

  logic [7:0]   slot_value [POOL_NODES];
  logic [6:0]   slot_next  [POOL_NODES];
  logic [6:0]   used_head;
  logic [6:0]   free_top;
  logic [6:0]   used_total;
  list_result_t due_results[$];
  int           mismatches = 0;

  assign fail_count = mismatches;

  function automatic pli_status_t pool_insert(logic [7:0] v);
    logic [6:0] n;
    n = free_top;
    if (n >= NIL) return ST_FULL;
    free_top      = slot_next[n];
    slot_value[n] = v;
    slot_next[n]  = used_head;
    used_head     = n;
    used_total    = used_total + 7'd1;
    return ST_DONE;
  endfunction

  function automatic pli_status_t pool_remove(logic [7:0] v);
    logic [6:0] cur;
    logic [6:0] prev;
    int         i;
    cur  = used_head;
    prev = NIL;
    for (i = 0; i < int'(used_total); i++) begin
      if (cur >= NIL) return ST_NOT_FOUND;
      if (slot_value[cur] == v) begin
        if (prev < NIL) slot_next[prev] = slot_next[cur];
        else used_head = slot_next[cur];
        slot_next[cur] = free_top;
        free_top       = cur;
        used_total     = used_total - 7'd1;
        return ST_DONE;
      end
      prev = cur;
      cur  = slot_next[cur];
    end
    return ST_NOT_FOUND;
  endfunction

  always @(posedge clk) begin
    list_result_t due;
    if (rst) begin
      for (int i = 0; i < POOL_NODES; i++) begin
        slot_value[i] = '0;
        slot_next[i]  = 7'(i + 1);
      end
      used_head  = NIL;
      free_top   = 7'd0;
      used_total = 7'd0;
      due_results.delete();
    end else begin
      if (in_valid && !in_stall) begin
        due.status = (op == OP_INSERT) ? pool_insert(value) : pool_remove(value);
        due.count  = used_total;
        due_results.push_back(due);
      end
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result: status %0d count %0d",
                   $time, status, occupied_count);
          mismatches++;
        end else begin
          due = due_results.pop_front();
          if (status !== due.status) begin
            $display("%0t: status mismatch: expected %0d got %0d",
                     $time, due.status, status);
            mismatches++;
          end
          if (occupied_count !== due.count) begin
            $display("%0t: occupied count mismatch: expected %0d got %0d",
                     $time, due.count, occupied_count);
            mismatches++;
          end
        end
      end
    end
    pending <= due_results.size();
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives insert and remove requests into the pooled list core: a short
// directed list, then random phases that swing between filling the pool and
// draining it, with random idle bursts on both channels and one long output
// hold-off. A checker beside the core predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import pli_pkg::*;

  localparam int POOL       = 64;
  localparam int RAND_REQS  = 1400;
  localparam int CALM_REQS  = 150;
  localparam int HOLD_AT    = 300;
  localparam int HOLD_LEN   = 400;
  localparam int STUCK_MAX  = 4000;
  localparam int DRAIN_WAIT = 80;

  logic       clk;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  logic       op        = OP_INSERT;
  logic [7:0] value     = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] status;
  logic [6:0] occupied_count;
  logic       calm      = 1'b0;
  logic       hold_go   = 1'b0;
  int         fail_count;
  int         pending;

  pooled_list_insert_remove_core #(.POOL_NODES(POOL), .VALUE_BITS(8)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .op(op), .value(value),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .occupied_count(occupied_count)
  );

  pooled_list_checker #(.POOL_NODES(POOL)) u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .op(op), .value(value),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .occupied_count(occupied_count),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // returns at the edge where the request is taken
  task automatic send_request(input logic o, input logic [7:0] v);
    in_valid <= 1'b1;
    op       <= o;
    value    <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic maybe_idle();
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  function automatic logic [7:0] pick_value();
    if ($urandom_range(0, 3) != 0) return 8'($urandom_range(0, 15));
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin : result_side
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STUCK_MAX) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck = 0;
      else stuck++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : request_side
    int bias;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty list, extremes of value, head/tail removes, duplicates
    send_request(OP_REMOVE, 8'h07);
    send_request(OP_INSERT, 8'h00);
    send_request(OP_INSERT, 8'hFF);
    maybe_idle();
    send_request(OP_INSERT, 8'h55);
    send_request(OP_INSERT, 8'hAA);
    send_request(OP_REMOVE, 8'h0F);
    send_request(OP_REMOVE, 8'h00);
    maybe_idle();
    send_request(OP_REMOVE, 8'hFF);
    send_request(OP_REMOVE, 8'hAA);
    send_request(OP_INSERT, 8'hAA);
    send_request(OP_INSERT, 8'hAA);
    send_request(OP_REMOVE, 8'hAA);
    maybe_idle();
    send_request(OP_REMOVE, 8'hAA);
    send_request(OP_REMOVE, 8'hAA);
    send_request(OP_REMOVE, 8'h55);
    send_request(OP_REMOVE, 8'h55);

    // phases swing insert bias so the pool fills, overflows and drains
    bias = 90;
    for (int n = 0; n < RAND_REQS; n++) begin
      if (n % 100 == 0) begin
        case ((n / 100) % 5)
          0: bias = 90;
          1: bias = 50;
          2: bias = 10;
          3: bias = 75;
          default: bias = 30;
        endcase
      end
      if (n == HOLD_AT) hold_go <= 1'b1;
      if (n == RAND_REQS - CALM_REQS) calm <= 1'b1;
      maybe_idle();
      send_request(($urandom_range(0, 99) < bias) ? OP_INSERT : OP_REMOVE,
                   pick_value());
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== pooled_list_insert_remove_core.f =====
hw/rtl/pli_pkg.sv
hw/rtl/pli_node_store.sv
hw/rtl/pooled_list_insert_remove_core.sv
dv/pooled_list_checker.sv
dv/testbench.sv
